// ===== rtl/i2cms_pkg.sv =====
// shared types, codes and sizes for the i2c master transaction sequencer
package i2cms_pkg;

	// message buffer geometry
	localparam int BUF_DEPTH = 32;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);
	localparam int PTR_W     = $clog2(BUF_DEPTH + 1);

	// fixed field widths
	localparam int CMD_W  = 3;
	localparam int IDX_W  = 5;
	localparam int BYTE_W = 8;
	localparam int SIZE_W = 6;
	localparam int EV_W   = 4;
	localparam int ACT_W  = 3;
	localparam int ERR_W  = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE   = 3'd0,
		CMD_START   = 3'd1,
		CMD_RESTART = 3'd2,
		CMD_EVENT   = 3'd3,
		CMD_READ    = 3'd4,
		CMD_QUERY   = 3'd5
	} cmd_t;

	typedef enum logic [EV_W-1:0] {
		EV_START       = 4'd0,
		EV_RESTART     = 4'd1,
		EV_WADR_ACK    = 4'd2,
		EV_WDATA_ACK   = 4'd3,
		EV_RDATA_ACK   = 4'd4,
		EV_RADR_ACK    = 4'd5,
		EV_RDATA_NACK  = 4'd6,
		EV_ARB_LOST    = 4'd7,
		EV_WADR_NACK   = 4'd8,
		EV_RADR_NACK   = 4'd9,
		EV_WDATA_NACK  = 4'd10,
		EV_BUS_ERROR   = 4'd11
	} ev_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE    = 3'd0,
		ACT_SEND    = 3'd1,
		ACT_RX_ACK  = 3'd2,
		ACT_RX_NACK = 3'd3,
		ACT_STOP    = 3'd4,
		ACT_START   = 3'd5,
		ACT_ABORT   = 3'd6
	} act_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE       = 3'd0,
		ERR_WADR_NACK  = 3'd1,
		ERR_RADR_NACK  = 3'd2,
		ERR_WDATA_NACK = 3'd3,
		ERR_BUS        = 3'd4,
		ERR_OTHER      = 3'd5
	} err_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [IDX_W-1:0]  index;
		logic [BYTE_W-1:0] data;
		logic [SIZE_W-1:0] msg_size;
		logic [EV_W-1:0]   event_req;
	} req_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [BYTE_W-1:0] tx_byte;
		logic [BYTE_W-1:0] read_byte;
		logic              busy_res;
		logic              done_res;
		logic [ERR_W-1:0]  error_code;
		logic              rejected;
	} rsp_t;

endpackage

// ===== rtl/i2cms_ram.sv =====
// generic single write port ram with registered read
module i2cms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/i2c_master_transaction_sequencer.sv =====
// top level: i2c master transaction sequencer with buffer ram and result pipeline
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  req     | in        | req_valid / req_stall  | req_t: command, index, data, ...
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_t: action, tx_byte, status
//
// one request per cycle while req_stall is low; every request gives exactly one response
// the control state and the buffer ram port update at the accepting edge, the
// ram read data and decoded result meet in the s1 stage, and the response
// register follows
// reset clears the control state and the stage valids; buffer bytes are undefined until written
// a stalled response holds s1, and req_stall rises only when both s1 and the
// response register are full
module i2c_master_transaction_sequencer
	import i2cms_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// control state
	logic [PTR_W-1:0] ptr_q, ptr_d;
	logic [PTR_W-1:0] len_q, len_d;
	logic             busy_q, busy_d;
	logic             done_q, done_d;
	logic [ERR_W-1:0] err_q, err_d;

	// decoded result of the current request
	logic [ACT_W-1:0] act_d;
	logic             rej_d;
	logic             tx_sel_d;
	logic             rd_sel_d;

	// buffer ram port
	logic              ram_we, ram_re;
	logic [BUF_AW-1:0] ram_waddr, ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	// helpers
	logic [PTR_W-1:0] base_ptr, base_adv, adv_ptr, len_m1, size_sat;
	logic             base_ok, ptr_ok, idx_ok, ev_reload;

	// pipeline control
	logic req_acc, s1_adv;
	logic valid_s1;
	logic [ACT_W-1:0] act_s1;
	logic             rej_s1, tx_sel_s1, rd_sel_s1, busy_s1, done_s1;
	logic [ERR_W-1:0] err_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;

	// handshake: s1 moves on whenever the response register is free or draining
	assign s1_adv    = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !s1_adv;
	assign req_acc   = req_valid && !req_stall;

	// start and restart events rewind the pointer to the address byte
	assign ev_reload = (req.event_req == EV_START) || (req.event_req == EV_RESTART);
	assign base_ptr  = ev_reload ? '0 : ptr_q;
	assign base_ok   = base_ptr < PTR_W'(BUF_DEPTH);
	assign base_adv  = base_ok ? base_ptr + PTR_W'(1) : base_ptr;
	assign ptr_ok    = ptr_q < PTR_W'(BUF_DEPTH);
	assign adv_ptr   = ptr_ok ? ptr_q + PTR_W'(1) : ptr_q;
	assign len_m1    = len_q - PTR_W'(1);
	assign idx_ok    = PTR_W'(req.index) < PTR_W'(BUF_DEPTH);

	// message length clamps into 1..depth
	always_comb begin
		if (req.msg_size == '0) begin
			size_sat = PTR_W'(1);
		end else if (req.msg_size > SIZE_W'(BUF_DEPTH)) begin
			size_sat = PTR_W'(BUF_DEPTH);
		end else begin
			size_sat = PTR_W'(req.msg_size);
		end
	end

	// next state and response decode
	always_comb begin
		ptr_d     = ptr_q;
		len_d     = len_q;
		busy_d    = busy_q;
		done_d    = done_q;
		err_d     = err_q;
		act_d     = ACT_NONE;
		rej_d     = 1'b0;
		tx_sel_d  = 1'b0;
		rd_sel_d  = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = ptr_q[BUF_AW-1:0];
		ram_raddr = base_ptr[BUF_AW-1:0];
		case (req.command)
			CMD_WRITE: begin
				ram_we    = idx_ok;
				ram_waddr = req.index[BUF_AW-1:0];
			end
			CMD_START, CMD_RESTART: begin
				if (busy_q) begin
					rej_d = 1'b1;
				end else begin
					if (req.command == CMD_START) begin
						len_d = size_sat;
					end
					done_d = 1'b0;
					err_d  = ERR_NONE;
					busy_d = 1'b1;
					act_d  = ACT_START;
				end
			end
			CMD_EVENT: begin
				if (busy_q) begin
					case (req.event_req)
						EV_START, EV_RESTART, EV_WADR_ACK, EV_WDATA_ACK: begin
							ptr_d = base_ptr;
							if (base_ptr < len_q) begin
								// send next byte; past the buffer it goes out as zero
								ram_re   = base_ok;
								tx_sel_d = base_ok;
								ptr_d    = base_adv;
								act_d    = ACT_SEND;
							end else begin
								done_d = 1'b1;
								busy_d = 1'b0;
								act_d  = ACT_STOP;
							end
						end
						EV_RDATA_ACK: begin
							ram_we = ptr_ok;
							ptr_d  = adv_ptr;
							act_d  = (adv_ptr < len_m1) ? ACT_RX_ACK : ACT_RX_NACK;
						end
						EV_RADR_ACK: begin
							act_d = (ptr_q < len_m1) ? ACT_RX_ACK : ACT_RX_NACK;
						end
						EV_RDATA_NACK: begin
							// last byte of a read lands without moving the pointer
							ram_we = ptr_ok;
							done_d = 1'b1;
							busy_d = 1'b0;
							act_d  = ACT_STOP;
						end
						EV_ARB_LOST: begin
							act_d = ACT_START;
						end
						EV_WADR_NACK: begin
							err_d  = ERR_WADR_NACK;
							busy_d = 1'b0;
							act_d  = ACT_ABORT;
						end
						EV_RADR_NACK: begin
							err_d  = ERR_RADR_NACK;
							busy_d = 1'b0;
							act_d  = ACT_ABORT;
						end
						EV_WDATA_NACK: begin
							err_d  = ERR_WDATA_NACK;
							busy_d = 1'b0;
							act_d  = ACT_ABORT;
						end
						EV_BUS_ERROR: begin
							err_d  = ERR_BUS;
							busy_d = 1'b0;
							act_d  = ACT_ABORT;
						end
						default: begin
							// unknown bus status codes
							err_d  = ERR_OTHER;
							busy_d = 1'b0;
							act_d  = ACT_ABORT;
						end
					endcase
				end
			end
			CMD_READ: begin
				ram_re    = idx_ok;
				rd_sel_d  = idx_ok;
				ram_raddr = req.index[BUF_AW-1:0];
			end
			default: begin
				// query and spare codes only report status
			end
		endcase
	end

	// message buffer; read data lines up with s1
	i2cms_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BUF_DEPTH)
	) u_buf (
		.clk  (clk),
		.we   (ram_we && req_acc),
		.waddr(ram_waddr),
		.wdata(req.data),
		.re   (ram_re && req_acc),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// control state commits at the accepting edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			len_q  <= PTR_W'(1);
			busy_q <= 1'b0;
			done_q <= 1'b0;
			err_q  <= ERR_NONE;
		end else if (req_acc) begin
			ptr_q  <= ptr_d;
			len_q  <= len_d;
			busy_q <= busy_d;
			done_q <= done_d;
			err_q  <= err_d;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (req_acc) begin
			act_s1    <= act_d;
			rej_s1    <= rej_d;
			tx_sel_s1 <= tx_sel_d;
			rd_sel_s1 <= rd_sel_d;
			busy_s1   <= busy_d;
			done_s1   <= done_d;
			err_s1    <= err_d;
		end
		if (s1_adv && valid_s1) begin
			rsp_q.action     <= act_s1;
			rsp_q.tx_byte    <= tx_sel_s1 ? ram_rdata : '0;
			rsp_q.read_byte  <= rd_sel_s1 ? ram_rdata : '0;
			rsp_q.busy_res   <= busy_s1;
			rsp_q.done_res   <= done_s1;
			rsp_q.error_code <= err_s1;
			rsp_q.rejected   <= rej_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// stall only comes from a full pipeline
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && rsp_valid_q && rsp_stall))
		else $error("request stalled while pipeline has room");

	// an accepted start while idle leaves the sequencer busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && !busy_q && (req.command == CMD_START || req.command == CMD_RESTART))
		|=> busy_q)
		else $error("start did not set busy");

	// length in use stays within the buffer and the pointer never runs past it
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != '0) && (len_q <= PTR_W'(BUF_DEPTH)) && (ptr_q <= PTR_W'(BUF_DEPTH)))
		else $error("length or pointer out of range");

	// a held s1 entry keeps its result
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(act_s1) && $stable(err_s1)))
		else $error("s1 changed while stalled");

endmodule
